// ===== rtl/lidar_bin_velocity_estimator_unit_macros.svh =====
// Assertion macros shared by the velocity estimator checker.
`ifndef LIDAR_BIN_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define LIDAR_BIN_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH

// Condition and consequence in the same cycle.
`define LBVE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbve check failed");

// Consequence in the cycle after the condition.
`define LBVE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbve check failed");

`endif

// ===== rtl/lbve_pkg.sv =====
// Shared widths and constants for the lidar bin velocity estimator.
package lbve_pkg;

  // Field widths
  localparam int BIN_W       = 9;
  localparam int RANGE_W     = 16;
  localparam int VEL_W       = 32;
  localparam int SCALE_W     = 25;

  // Q9.16 scale: fraction bits and rounding half
  localparam int FRAC_W      = 16;
  localparam int ROUND_HALF  = 32768;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd218453;

  // Stream bus widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

endpackage

// ===== rtl/lbve_hist_mem.sv =====
// Per-bin range history memory with a zeroing pass after reset.
module lbve_hist_mem #(
  parameter int DEPTH = 360,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic                     clr_busy
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic             clr_busy_r;
  logic [AW-1:0]    clr_cnt_r;

  // Zeroing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/lidar_bin_velocity_estimator_unit.sv =====
// Top level of the lidar bin velocity estimator.
// Accepts one range sample per cycle while in_tready is high and returns one result per sample
// through the registered stages memory read, hole fill and difference, scale multiply, and
// round and clamp. Throughput is one beat per cycle while the output is not stalled, set by
// the history memory's single read and single write port; a sample for the same bin as the
// one just before it is served by a bypass of the pending write-back. After reset the
// NUM_BINS history entries are zeroed while in_tready stays low; configuration writes are
// taken at any time. A bin at or above NUM_BINS leaves the history alone and returns zeros.
module lidar_bin_velocity_estimator_unit
  import lbve_pkg::*;
#(
  parameter int NUM_BINS   = 360,
  parameter int RANGE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Sample stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [8:0] bin_index, [24:9] range_mm
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [8:0] out_bin, [24:9] filled_range_mm,
                                             // [56:25] velocity_mm_s
  output logic                   out_tuser,  // [0] saturated
  // Scale register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SCALE_W-1:0]     cfg_data
);

  localparam int SW      = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam int AW      = $clog2(NUM_BINS);
  localparam int XW      = (AW > BIN_W) ? AW : BIN_W;
  localparam int MW      = 3 * SW;
  localparam int DW      = SW + 3;
  localparam int PW      = DW + SCALE_W + 1;
  localparam int OUT_PAD = OUT_TDATA_W - BIN_W - RANGE_W - VEL_W;

  localparam logic signed [PW-1:0] VEL_MAX = {{(PW - VEL_W + 1){1'b0}}, {(VEL_W - 1){1'b1}}};
  localparam logic signed [PW-1:0] VEL_MIN = {{(PW - VEL_W + 1){1'b1}}, {(VEL_W - 1){1'b0}}};
  localparam logic [VEL_W-1:0]     SAT_HI  = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic [VEL_W-1:0]     SAT_LO  = {1'b1, {(VEL_W - 1){1'b0}}};

  // Scale register
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline handshake
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;
  logic clr_busy;
  logic in_fire;

  assign rdyo      = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdyo;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1 && !clr_busy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_fire;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  // Input unpack
  logic [BIN_W-1:0] in_bin;
  logic [XW-1:0]    in_bin_x;
  logic [AW-1:0]    in_addr;
  logic             in_inr;

  assign in_bin   = in_tdata[BIN_W-1:0];
  assign in_bin_x = XW'(in_bin);
  assign in_addr  = in_bin_x[AW-1:0];
  assign in_inr   = 32'(in_bin) < 32'(NUM_BINS);

  // Stage 1: memory read data arrives
  logic [BIN_W-1:0] bin1_r;
  logic [SW-1:0]    rng1_r;
  logic             inr1_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bin1_r <= in_bin;
      rng1_r <= in_tdata[BIN_W +: SW];
      inr1_r <= in_inr;
    end
  end

  logic [MW-1:0]  rd_data;
  logic [MW-1:0]  word1;
  logic [XW-1:0]  bin1_x;
  logic [AW-1:0]  addr1;
  logic [SW-1:0]  h1, h2, h3, cur_nxt;
  logic [MW-1:0]  wb_data;
  logic           wb_en;
  logic signed [DW-1:0] diff_nxt;

  // Bypass of the write that lands on the same edge as the read
  logic          byp_vld_r;
  logic [AW-1:0] byp_addr_r;
  logic [MW-1:0] byp_data_r;

  assign bin1_x = XW'(bin1_r);
  assign addr1  = bin1_x[AW-1:0];
  assign word1  = (byp_vld_r && (byp_addr_r == addr1)) ? byp_data_r : rd_data;
  assign h1     = word1[SW-1:0];
  assign h2     = word1[2*SW-1:SW];
  assign h3     = word1[3*SW-1:2*SW];

  // Hole fill: the current range if nonzero, else the newest nonzero of the history
  always_comb begin
    if (rng1_r != '0) begin
      cur_nxt = rng1_r;
    end else if (h1 != '0) begin
      cur_nxt = h1;
    end else if (h2 != '0) begin
      cur_nxt = h2;
    end else begin
      cur_nxt = h3;
    end
  end

  // History shift and write-back
  assign wb_data  = {h2, h1, cur_nxt};
  assign wb_en    = v1_r && rdy2 && inr1_r;
  assign diff_nxt = $signed(DW'(cur_nxt) + DW'({cur_nxt, 1'b0})
                            - DW'(h1) - DW'(h2) - DW'(h3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (in_fire) begin
      byp_vld_r <= wb_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_addr_r <= addr1;
      byp_data_r <= wb_data;
    end
  end

  lbve_hist_mem #(
    .DEPTH (NUM_BINS),
    .WIDTH (MW)
  ) u_hist_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire && in_inr),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wb_en),
    .wr_addr  (addr1),
    .wr_data  (wb_data),
    .clr_busy (clr_busy)
  );

  // Stage 2: difference
  logic [BIN_W-1:0]     bin2_r;
  logic [SW-1:0]        cur2_r;
  logic                 inr2_r;
  logic signed [DW-1:0] diff2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      bin2_r  <= bin1_r;
      cur2_r  <= cur_nxt;
      inr2_r  <= inr1_r;
      diff2_r <= diff_nxt;
    end
  end

  // Stage 3: scale multiply
  logic [BIN_W-1:0]     bin3_r;
  logic [SW-1:0]        cur3_r;
  logic                 inr3_r;
  logic signed [PW-1:0] prod3_r;
  logic signed [PW-1:0] prod_nxt;

  assign prod_nxt = PW'(diff2_r) * PW'($signed({1'b0, scale_r}));

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      bin3_r  <= bin2_r;
      cur3_r  <= cur2_r;
      inr3_r  <= inr2_r;
      prod3_r <= prod_nxt;
    end
  end

  // Output stage: round half up, clamp to 32 bits
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] quo;
  logic [VEL_W-1:0]     vel_nxt;
  logic                 sat_nxt;

  assign rnd = prod3_r + PW'(ROUND_HALF);
  assign quo = rnd >>> FRAC_W;

  always_comb begin
    if (!inr3_r) begin
      vel_nxt = '0;
      sat_nxt = 1'b0;
    end else if (quo > VEL_MAX) begin
      vel_nxt = SAT_HI;
      sat_nxt = 1'b1;
    end else if (quo < VEL_MIN) begin
      vel_nxt = SAT_LO;
      sat_nxt = 1'b1;
    end else begin
      vel_nxt = quo[VEL_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  logic [BIN_W-1:0]   bino_r;
  logic [RANGE_W-1:0] rngo_r;
  logic [VEL_W-1:0]   velo_r;
  logic               sato_r;

  always_ff @(posedge clk) begin
    if (rdyo && v3_r) begin
      bino_r <= bin3_r;
      rngo_r <= inr3_r ? RANGE_W'(cur3_r) : '0;
      velo_r <= vel_nxt;
      sato_r <= sat_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, velo_r, rngo_r, bino_r};
  assign out_tuser  = sato_r;

endmodule

// ===== rtl/lbve_chk.sv =====
// Port-level checker for the lidar bin velocity estimator, bound to the top level.
`include "lidar_bin_velocity_estimator_unit_macros.svh"

module lbve_chk
  import lbve_pkg::*;
#(
  parameter int NUM_BINS = 360
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  localparam logic [VEL_W-1:0] SAT_HI = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic [VEL_W-1:0] SAT_LO = {1'b1, {(VEL_W - 1){1'b0}}};

  logic [BIN_W-1:0]   out_bin;
  logic [RANGE_W-1:0] out_rng;
  logic [VEL_W-1:0]   out_vel;
  logic               oob;
  logic               oob_zero;
  logic               sat_val;
  logic               vel_not_pos;

  assign out_bin     = out_tdata[BIN_W-1:0];
  assign out_rng     = out_tdata[BIN_W +: RANGE_W];
  assign out_vel     = out_tdata[BIN_W + RANGE_W +: VEL_W];
  assign oob         = 32'(out_bin) >= 32'(NUM_BINS);
  assign oob_zero    = (out_rng == '0) && (out_vel == '0) && !out_tuser;
  assign sat_val     = (out_vel == SAT_HI) || (out_vel == SAT_LO);
  assign vel_not_pos = out_vel[VEL_W-1] || (out_vel == '0);

  // Out-of-range bins return all-zero results
  `LBVE_ASSERT_NOW(a_oob_zero, out_tvalid && oob, oob_zero)

  // Clipping flag only with a clamped value
  `LBVE_ASSERT_NOW(a_sat_value, out_tvalid && out_tuser, sat_val)

  // With no range anywhere in the history the velocity cannot be positive
  `LBVE_ASSERT_NOW(a_zero_range_vel, out_tvalid && !oob && out_rng == '0, vel_not_pos)

  // A stalled result beat holds
  `LBVE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind lidar_bin_velocity_estimator_unit lbve_chk #(
  .NUM_BINS (NUM_BINS)
) u_lbve_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
